>>> sv/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> sv/x86rms_pkg.sv
// Package with types and constants of the x86 register, memory and stack unit.
package x86rms_pkg;

   localparam int MEM_BYTES_DEF = 65536;
   localparam int STACK_REG_DEF = 4;

   // Request kinds carried in the low bits of req_tuser.
   typedef enum logic [2:0] {
      REQ_REG_RD = 3'd0,
      REQ_REG_WR = 3'd1,
      REQ_MEM_RD = 3'd2,
      REQ_MEM_WR = 3'd3,
      REQ_PUSH   = 3'd4,
      REQ_POP    = 3'd5
   } req_kind_type;

   // Access sizes; code three is meaningless and is rejected.
   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } size_type;

   localparam logic [31:0] KEEP_HI16   = 32'hffff0000;
   localparam logic [31:0] KEEP_NO_LO8 = 32'hffffff00;
   localparam logic [31:0] KEEP_NO_B1  = 32'hffff00ff;
   localparam logic [31:0] MASK_LO8    = 32'h000000FF;
   localparam logic [31:0] MASK_LO16   = 32'h0000ffff;

endpackage

>>> sv/x86_register_memory_stack_unit_top.sv
// Top level of the x86 register, memory and stack unit.
//
// The unit holds eight 32-bit general registers and a byte memory split into
// four byte-lane banks. One request item enters on the req_ channel and one
// response item leaves on the rsp_ channel for every request. Register reads
// and writes, memory reads and writes of 8, 16 or 32 bits (little-endian, any
// alignment) and 16- or 32-bit push and pop through the stack register are
// supported. Out-of-range memory bytes are skipped, read as zero and set the
// error flag; size code three, unknown kinds and byte-sized push or pop set
// the error flag and change nothing.
// On acceptance, registers are updated and the active, in-range banks are
// written or read at that edge. Stage one then holds the item while the bank
// read data is registered and until the response register is free; that
// register then loads it and offers the response. Stage one keeps req_tready
// low while it holds an item, so no new item is accepted until it has left.
// The response register lets the next item be accepted while a response
// still waits; if the receiver keeps rsp_tready low, the finished item is
// held and req_tready stays low until the response register frees up.
// Reset clears the registers and the channel control; memory contents stay
// undefined until written and need no clearing pass.
`include "assert_macros.svh"

module x86_register_memory_stack_unit_top #(
   parameter int MEM_BYTES = x86rms_pkg::MEM_BYTES_DEF,
   parameter int STACK_REG = x86rms_pkg::STACK_REG_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] reg_index, [34:3] mem_address, [66:35] write_data, [71:67] zero
   input  logic [71:0] req_tdata,
   // [2:0] req_type, [4:3] access_size
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_data
   output logic [31:0] rsp_tdata,
   // [0] access_error
   output logic [0:0]  rsp_tuser
);

   // Each bank holds every fourth byte; the lane is the low two address bits.
   localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
   localparam int ROW_W      = $clog2(BANK_DEPTH);
   localparam logic [2:0]  SP_IDX   = 3'(STACK_REG);
   localparam logic [31:0] MEM_TOP  = 32'(MEM_BYTES);

   // Request fields.
   logic [2:0]  req_type;
   logic [1:0]  access_size;
   logic [2:0]  reg_index;
   logic [31:0] mem_address;
   logic [31:0] write_data;

   assign req_type    = req_tuser[2:0];
   assign access_size = req_tuser[4:3];
   assign reg_index   = req_tdata[2:0];
   assign mem_address = req_tdata[34:3];
   assign write_data  = req_tdata[66:35];

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // General registers.
   logic [31:0] regs_ff [8];
   logic [31:0] regs_in [8];

   // Stage one: the accepted item waiting for bank read data.
   logic        pend_ff,      pend_in;
   logic        pend_mem_ff,  pend_mem_in;
   logic [31:0] pend_rd_ff,   pend_rd_in;
   logic        pend_err_ff,  pend_err_in;
   logic [1:0]  pend_base_ff, pend_base_in;
   logic [3:0]  pend_ok_ff,   pend_ok_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff,  rsp_data_in;
   logic        rsp_err_ff,   rsp_err_in;

   logic out_load;
   assign out_load   = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff;

   // Decode.
   logic        size_ok;
   logic        kind_ok;
   logic        is_stack;
   logic        is_mem_rd;
   logic        is_mem_wr;
   logic        op_ok;
   logic [2:0]  nbytes;
   logic [31:0] nbytes32;
   logic [31:0] sp_val;
   logic [31:0] acc_addr;
   logic        hi_byte;
   logic [2:0]  rd_idx;
   logic [31:0] rd_reg;
   logic [31:0] reg_rd_val;

   always_comb begin
      size_ok = 1'b1;
      nbytes  = 3'd4;
      case (access_size)
         x86rms_pkg::SIZE_BYTE: nbytes = 3'd1;
         x86rms_pkg::SIZE_HALF: nbytes = 3'd2;
         x86rms_pkg::SIZE_WORD: nbytes = 3'd4;
         default:               size_ok = 1'b0;
      endcase
   end

   assign nbytes32 = {29'd0, nbytes};
   assign kind_ok  = req_type inside {x86rms_pkg::REQ_REG_RD, x86rms_pkg::REQ_REG_WR,
                                      x86rms_pkg::REQ_MEM_RD, x86rms_pkg::REQ_MEM_WR,
                                      x86rms_pkg::REQ_PUSH, x86rms_pkg::REQ_POP};
   assign is_stack = req_type inside {x86rms_pkg::REQ_PUSH, x86rms_pkg::REQ_POP};
   // A byte-sized push or pop is rejected like a bad size.
   assign op_ok    = size_ok && kind_ok &&
                     !(is_stack && access_size == x86rms_pkg::SIZE_BYTE);
   assign is_mem_rd = op_ok && (req_type == x86rms_pkg::REQ_MEM_RD ||
                                req_type == x86rms_pkg::REQ_POP);
   assign is_mem_wr = op_ok && (req_type == x86rms_pkg::REQ_MEM_WR ||
                                req_type == x86rms_pkg::REQ_PUSH);

   assign sp_val = regs_ff[SP_IDX];

   always_comb begin
      case (req_type)
         x86rms_pkg::REQ_PUSH: acc_addr = sp_val - nbytes32;
         x86rms_pkg::REQ_POP:  acc_addr = sp_val;
         default:              acc_addr = mem_address;
      endcase
   end

   // Byte accesses to indexes four to seven reach bits 15:8 of registers 0-3.
   assign hi_byte = (access_size == x86rms_pkg::SIZE_BYTE) && reg_index[2];
   assign rd_idx  = hi_byte ? {1'b0, reg_index[1:0]} : reg_index;
   assign rd_reg  = regs_ff[rd_idx];

   always_comb begin
      case (access_size)
         x86rms_pkg::SIZE_BYTE:
            reg_rd_val = hi_byte ? ((rd_reg >> 8) & x86rms_pkg::MASK_LO8)
                                 : (rd_reg & x86rms_pkg::MASK_LO8);
         x86rms_pkg::SIZE_HALF: reg_rd_val = rd_reg & x86rms_pkg::MASK_LO16;
         default:               reg_rd_val = rd_reg;
      endcase
   end

   // Register file update: at most one register changes per item.
   always_comb begin
      for (int r = 0; r < 8; r++) begin
         regs_in[r] = regs_ff[r];
      end
      if (req_acc && op_ok) begin
         case (req_type)
            x86rms_pkg::REQ_REG_WR: begin
               case (access_size)
                  x86rms_pkg::SIZE_BYTE:
                     regs_in[rd_idx] = hi_byte
                        ? ((rd_reg & x86rms_pkg::KEEP_NO_B1) |
                           ((write_data & x86rms_pkg::MASK_LO8) << 8))
                        : ((rd_reg & x86rms_pkg::KEEP_NO_LO8) |
                           (write_data & x86rms_pkg::MASK_LO8));
                  x86rms_pkg::SIZE_HALF:
                     regs_in[rd_idx] = (rd_reg & x86rms_pkg::KEEP_HI16) |
                                       (write_data & x86rms_pkg::MASK_LO16);
                  default: regs_in[rd_idx] = write_data;
               endcase
            end
            x86rms_pkg::REQ_PUSH: regs_in[SP_IDX] = acc_addr;
            x86rms_pkg::REQ_POP:  regs_in[SP_IDX] = sp_val + nbytes32;
            default: ;
         endcase
      end
   end

   // Per-lane address generation: lane l holds byte offset (l - base) mod 4.
   logic [3:0]       lane_we;
   logic [3:0]       lane_re;
   logic [3:0]       lane_bad;
   logic [ROW_W-1:0] lane_row [4];
   logic [7:0]       lane_wbyte [4];
   logic [3:0]       off_ok;

   always_comb begin
      logic [1:0]  off;
      logic [31:0] ba;
      logic        active;
      logic        in_mem;
      off_ok = 4'd0;
      for (int l = 0; l < 4; l++) begin
         off    = 2'(l) - acc_addr[1:0];
         ba     = acc_addr + {30'd0, off};
         active = {1'b0, off} < nbytes;
         in_mem = ba < MEM_TOP;
         lane_row[l]   = ba[ROW_W+1:2];
         lane_wbyte[l] = write_data[8*off +: 8];
         lane_we[l]    = req_acc && is_mem_wr && active && in_mem;
         lane_re[l]    = req_acc && is_mem_rd && active && in_mem;
         lane_bad[l]   = active && !in_mem;
         off_ok[off]   = active && in_mem;
      end
   end

   // Four byte-lane banks with registered read data.
   logic [7:0] lane_rd [4];

   for (genvar ln = 0; ln < 4; ln++) begin : g_bank
      logic [7:0] bank [BANK_DEPTH];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (lane_we[ln]) begin
            bank[lane_row[ln]] <= lane_wbyte[ln];
         end
         if (lane_re[ln]) begin
            rd_ff <= bank[lane_row[ln]];
         end
      end

      assign lane_rd[ln] = rd_ff;
   end

   // Stage one capture.
   always_comb begin
      pend_in      = pend_ff;
      pend_mem_in  = pend_mem_ff;
      pend_rd_in   = pend_rd_ff;
      pend_err_in  = pend_err_ff;
      pend_base_in = pend_base_ff;
      pend_ok_in   = pend_ok_ff;
      if (out_load) begin
         pend_in = 1'b0;
      end
      if (req_acc) begin
         pend_in      = 1'b1;
         pend_mem_in  = is_mem_rd;
         pend_rd_in   = (op_ok && req_type == x86rms_pkg::REQ_REG_RD) ? reg_rd_val : 32'd0;
         pend_err_in  = !op_ok || ((is_mem_rd || is_mem_wr) && (lane_bad != 4'd0));
         pend_base_in = acc_addr[1:0];
         pend_ok_in   = off_ok;
      end
   end

   // Little-endian assembly of the bank read data; missing bytes read as zero.
   logic [31:0] mem_rd_val;

   always_comb begin
      logic [1:0] lane;
      for (int i = 0; i < 4; i++) begin
         lane = pend_base_ff + 2'(i);
         mem_rd_val[8*i +: 8] = pend_ok_ff[i] ? lane_rd[lane] : 8'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_mem_ff ? mem_rd_val : pend_rd_ff;
         rsp_err_in   = pend_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 8; r++) begin
            regs_ff[r] <= 32'd0;
         end
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < 8; r++) begin
            regs_ff[r] <= regs_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_mem_ff  <= pend_mem_in;
      pend_rd_ff   <= pend_rd_in;
      pend_err_ff  <= pend_err_in;
      pend_base_ff <= pend_base_in;
      pend_ok_ff   <= pend_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

   // An accepted item is always waiting in stage one on the next cycle.
   `ASSERT_NEXT(a_acc_pend, req_acc, pend_ff)
   // A stage-one item blocked by a full response register stays put.
   `ASSERT_NEXT(a_pend_hold, pend_ff && !out_load, pend_ff && $stable(pend_rd_ff))
   // A push lowers the stack register by the access size.
   `ASSERT_NEXT(a_push_sp, req_acc && op_ok && req_type == x86rms_pkg::REQ_PUSH,
                regs_ff[SP_IDX] == $past(sp_val) - $past(nbytes32))
   // Banks are touched only when an item is accepted.
   `ASSERT_IMPL(a_bank_acc, (lane_we != 4'd0) || (lane_re != 4'd0), req_acc)

endmodule
